[rtl/rlpd_pkg.sv]
// Shared types and constants for the RGB LED PWM shift driver.
package rlpd_pkg;

	localparam int NUM_LEDS_DEF     = 32;
	localparam int PWM_LEVELS_DEF   = 256;
	localparam int START_OFFSET_DEF = 4;

	localparam int LEVEL_W = 8;
	localparam int INDEX_W = 8;

	// request kinds carried on s_tuser
	localparam logic [1:0] REQ_WR_ONE = 2'd0;
	localparam logic [1:0] REQ_WR_ALL = 2'd1;
	localparam logic [1:0] REQ_TICK   = 2'd2;

	typedef struct packed {
		logic [LEVEL_W-1:0] r;
		logic [LEVEL_W-1:0] g;
		logic [LEVEL_W-1:0] b;
	} rgb_t;

	// broadcast from the sequencer to every cell
	typedef struct packed {
		logic               wr_one;
		logic               wr_all;
		logic               copy;
		logic               shift;
		logic [INDEX_W-1:0] index;
		rgb_t               level;
	} cell_ctrl_t;

endpackage

[rtl/rlpd_cell.sv]
// One LED cell: live level, snapshot level and the snapshot ring link.
module rlpd_cell
	import rlpd_pkg::*;
#(
	parameter int CELL_ID = 0
) (
	input  logic       clk,
	input  logic       arst_n,
	input  cell_ctrl_t ctrl,
	input  rgb_t       snap_in,
	output rgb_t       snap_out
);

	rgb_t live_q;
	rgb_t snap_q;
	logic hit;

	assign hit      = ctrl.wr_all || (ctrl.wr_one && (ctrl.index == INDEX_W'(CELL_ID)));
	assign snap_out = snap_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			live_q <= '0;
			snap_q <= '0;
		end else begin
			if (hit) begin
				live_q <= ctrl.level;
			end
			if (ctrl.copy) begin
				snap_q <= live_q;
			end else if (ctrl.shift) begin
				snap_q <= snap_in;
			end
		end
	end

endmodule

[rtl/rgb_led_pwm_shift_driver_core.sv]
// Top level: LED cell ring and frame sequencer of the RGB LED PWM shift driver.
//
//  channel | dir | fields                                   | accepted when
//  s_*     | in  | tuser=req_type, tdata=index,r,g,b        | s_tvalid && s_tready
//  m_*     | out | tdata=shift_byte, tlast=frame_end        | m_tvalid && m_tready
//
// A frame tick rotates the snapshot ring one cell per cycle while the output
// accepts, and a byte leaves every second rotation.
// A stalled output holds the ring at the byte step; s_tready is low for the frame.
// Reset clears all levels and the phase at once; no clearing pass.
module rgb_led_pwm_shift_driver_core
	import rlpd_pkg::*;
#(
	parameter int NUM_LEDS     = NUM_LEDS_DEF,
	parameter int PWM_LEVELS   = PWM_LEVELS_DEF,
	parameter int START_OFFSET = START_OFFSET_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // led_index[7:0], red[15:8], green[23:16], blue[31:24]
	input  logic [1:0]  s_tuser,   // req_type[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // shift_byte[7:0]
	output logic        m_tlast
);

	localparam int CW        = $clog2(NUM_LEDS);
	localparam int PW        = $clog2(PWM_LEVELS);
	localparam int TAP       = (START_OFFSET % NUM_LEDS + NUM_LEDS - 1) % NUM_LEDS;
	localparam int LAST_STEP = NUM_LEDS - 1;
	localparam int LAST_BYTE = 2 * (NUM_LEDS / 2) - 1;

	cell_ctrl_t     ctrl;
	rgb_t           snap [NUM_LEDS];
	rgb_t           tap;
	logic           busy_q;
	logic [CW-1:0]  cnt_q;
	logic [PW-1:0]  phase_q;
	logic [2:0]     lo_q;
	logic [2:0]     bits;
	logic [LEVEL_W-1:0] ph_ext;
	logic           accept;
	logic           tick;
	logic           step_en;
	logic           byte_step;

	// ring: each cell takes the snapshot of its lower neighbor
	for (genvar i = 0; i < NUM_LEDS; i++) begin : g_cell
		localparam int PREV = (i + NUM_LEDS - 1) % NUM_LEDS;
		rlpd_cell #(.CELL_ID(i)) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.ctrl    (ctrl),
			.snap_in (snap[PREV]),
			.snap_out(snap[i])
		);
	end

	assign s_tready = !busy_q;
	assign accept   = s_tvalid && s_tready;
	assign tick     = accept && (s_tuser == REQ_TICK);

	assign byte_step = cnt_q[0];
	assign step_en   = busy_q && (!byte_step || !m_tvalid || m_tready);

	assign tap    = snap[TAP];
	assign ph_ext = LEVEL_W'(phase_q);
	assign bits   = {tap.r > ph_ext, tap.g > ph_ext, tap.b > ph_ext};

	always_comb begin
		ctrl.wr_one = accept && (s_tuser == REQ_WR_ONE);
		ctrl.wr_all = accept && (s_tuser == REQ_WR_ALL);
		ctrl.copy   = tick && (phase_q == '0);
		ctrl.shift  = step_en;
		ctrl.index  = s_tdata[7:0];
		ctrl.level  = '{r: s_tdata[15:8], g: s_tdata[23:16], b: s_tdata[31:24]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q   <= 1'b0;
			cnt_q    <= '0;
			phase_q  <= '0;
			m_tvalid <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				m_tvalid <= 1'b0;
			end
			if (tick) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end
			if (step_en) begin
				if (byte_step) begin
					m_tvalid <= 1'b1;
				end
				if (cnt_q == CW'(LAST_STEP)) begin
					busy_q <= 1'b0;
					cnt_q  <= '0;
					phase_q <= (phase_q == PW'(PWM_LEVELS - 1)) ? '0 : phase_q + 1'b1;
				end else begin
					cnt_q <= cnt_q + 1'b1;
				end
			end
		end
	end

	// payload: first LED of the pair is held, second one closes the byte
	always_ff @(posedge clk) begin
		if (step_en) begin
			if (byte_step) begin
				m_tdata <= {bits, lo_q, 2'b00};
				m_tlast <= (cnt_q == CW'(LAST_BYTE));
			end else begin
				lo_q <= bits;
			end
		end
	end

endmodule
